FILE: src/htc_pkg.sv
`timescale 1ns / 1ps
package htc_pkg;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [15:0] raw_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [16:0]        hum_q10;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        temp_cal_one;
    logic signed [15:0] temp_cal_two;
    logic signed [15:0] temp_cal_three;
    logic [7:0]         hum_cal_one;
    logic signed [15:0] hum_cal_two;
    logic [7:0]         hum_cal_three;
    logic [23:0]        hum_cal_four_five_bytes;
    logic signed [7:0]  hum_cal_six;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [14:0] temp_centi;
    logic [15:0]        raw_hum;
  } temp_res_t;

  typedef enum logic [2:0] {
    REG_TEMP_CAL_ONE   = 3'd0,
    REG_TEMP_CAL_TWO   = 3'd1,
    REG_TEMP_CAL_THREE = 3'd2,
    REG_HUM_CAL_ONE    = 3'd3,
    REG_HUM_CAL_TWO    = 3'd4,
    REG_HUM_CAL_THREE  = 3'd5,
    REG_HUM_CAL_FOUR5  = 3'd6,
    REG_HUM_CAL_SIX    = 3'd7
  } reg_idx_t;

  localparam int PADDR_W = 5;

  localparam logic signed [31:0] TEMP_ROUND    = 32'sd128;
  localparam logic signed [31:0] TEMP_MIN      = -32'sd4000;
  localparam logic signed [31:0] TEMP_MAX      = 32'sd8500;
  localparam logic signed [31:0] FINE_HUM_OFS  = 32'sd76800;
  localparam logic signed [31:0] HUM_A_ROUND   = 32'sd16384;
  localparam logic signed [31:0] HUM_C_OFS     = 32'sd32768;
  localparam logic signed [31:0] HUM_B_OFS     = 32'sd2097152;
  localparam logic signed [31:0] HUM_B_ROUND   = 32'sd8192;
  localparam logic signed [31:0] HUM_MAX       = 32'sd419430400;

endpackage

FILE: src/htc_temp_pipe.sv
`timescale 1ns / 1ps
module htc_temp_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  htc_pkg::cal_t       cal,
  input  logic                in_valid,
  output logic                in_ready,
  input  htc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output htc_pkg::temp_res_t  out_data
);
  import htc_pkg::*;

  localparam int Stages = 4;

  logic [Stages-1:0] vld_r;
  logic [Stages:0]   rdy;

  logic signed [31:0] adc_t, t1, t2, t3, diff, m1_nxt, dd_nxt;
  logic signed [31:0] m1_r, dd_r;
  logic [15:0]        hum0_r, hum1_r, hum2_r, hum3_r;
  logic signed [31:0] v1_r, v2p_r, v1_nxt, v2p_nxt;
  logic signed [31:0] fine2_r, fine3_r, fine_nxt;
  logic signed [31:0] t5, t_full;
  logic signed [14:0] temp_nxt, temp_r;

  always_comb begin
    rdy[Stages] = out_ready;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[Stages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_comb begin
    adc_t  = {12'd0, in_data.raw_temp};
    t1     = {16'd0, cal.temp_cal_one};
    t2     = {{16{cal.temp_cal_two[15]}}, cal.temp_cal_two};
    m1_nxt = ((adc_t >>> 3) - (t1 <<< 1)) * t2;
    diff   = (adc_t >>> 4) - t1;
    dd_nxt = diff * diff;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m1_r   <= m1_nxt;
      dd_r   <= dd_nxt;
      hum0_r <= in_data.raw_hum;
    end
  end

  always_comb begin
    t3      = {{16{cal.temp_cal_three[15]}}, cal.temp_cal_three};
    v1_nxt  = m1_r >>> 11;
    v2p_nxt = (dd_r >>> 12) * t3;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      v1_r   <= v1_nxt;
      v2p_r  <= v2p_nxt;
      hum1_r <= hum0_r;
    end
  end

  assign fine_nxt = v1_r + (v2p_r >>> 14);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      fine2_r <= fine_nxt;
      hum2_r  <= hum1_r;
    end
  end

  always_comb begin
    t5     = (fine2_r <<< 2) + fine2_r;
    t_full = (t5 + TEMP_ROUND) >>> 8;
    if (t_full < TEMP_MIN) begin
      temp_nxt = TEMP_MIN[14:0];
    end else if (t_full > TEMP_MAX) begin
      temp_nxt = TEMP_MAX[14:0];
    end else begin
      temp_nxt = t_full[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      fine3_r <= fine2_r;
      temp_r  <= temp_nxt;
      hum3_r  <= hum2_r;
    end
  end

  assign out_data.fine       = fine3_r;
  assign out_data.temp_centi = temp_r;
  assign out_data.raw_hum    = hum3_r;

endmodule

FILE: src/htc_hum_pipe.sv
`timescale 1ns / 1ps
module htc_hum_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  htc_pkg::cal_t       cal,
  input  logic                in_valid,
  output logic                in_ready,
  input  htc_pkg::temp_res_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output htc_pkg::out_item_t  out_data
);
  import htc_pkg::*;

  localparam int Stages = 7;

  logic [Stages-1:0] vld_r;
  logic [Stages:0]   rdy;

  logic signed [31:0] h1, h2, h3, h4, h5, h6, adc_h, x0;
  logic signed [31:0] px5_nxt, px6_nxt, px3_nxt, abase_nxt;
  logic signed [31:0] px5_r, px6_r, px3_r, abase_r;
  logic signed [31:0] a_nxt, cfac, mbc_nxt, a1_r, mbc_r;
  logic signed [31:0] bsum, mb2_nxt, a2_r, mb2_r;
  logic signed [31:0] bfac, x_nxt, x3_r;
  logic signed [31:0] s15, sq_nxt, x4_r, sq_r;
  logic signed [31:0] mh_nxt, x5_r, mh_r;
  logic signed [31:0] r_full;
  logic [16:0]        hum_nxt, hum_r;
  logic signed [14:0] temp0_r, temp1_r, temp2_r, temp3_r, temp4_r, temp5_r, temp6_r;

  always_comb begin
    rdy[Stages] = out_ready;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[Stages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_comb begin
    h1 = {24'd0, cal.hum_cal_one};
    h2 = {{16{cal.hum_cal_two[15]}}, cal.hum_cal_two};
    h3 = {24'd0, cal.hum_cal_three};
    h4 = {{20{cal.hum_cal_four_five_bytes[7]}}, cal.hum_cal_four_five_bytes[7:0],
          cal.hum_cal_four_five_bytes[11:8]};
    h5 = {{20{cal.hum_cal_four_five_bytes[23]}}, cal.hum_cal_four_five_bytes[23:16],
          cal.hum_cal_four_five_bytes[15:12]};
    h6 = {{24{cal.hum_cal_six[7]}}, cal.hum_cal_six};
  end

  // stage 0: offsets from fine temperature
  always_comb begin
    adc_h     = {16'd0, in_data.raw_hum};
    x0        = in_data.fine - FINE_HUM_OFS;
    px5_nxt   = h5 * x0;
    px6_nxt   = x0 * h6;
    px3_nxt   = x0 * h3;
    abase_nxt = (adc_h <<< 14) - (h4 <<< 20) + HUM_A_ROUND;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      px5_r   <= px5_nxt;
      px6_r   <= px6_nxt;
      px3_r   <= px3_nxt;
      abase_r <= abase_nxt;
      temp0_r <= in_data.temp_centi;
    end
  end

  always_comb begin
    a_nxt   = (abase_r - px5_r) >>> 15;
    cfac    = (px3_r >>> 11) + HUM_C_OFS;
    mbc_nxt = (px6_r >>> 10) * cfac;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      a1_r    <= a_nxt;
      mbc_r   <= mbc_nxt;
      temp1_r <= temp0_r;
    end
  end

  always_comb begin
    bsum    = (mbc_r >>> 10) + HUM_B_OFS;
    mb2_nxt = bsum * h2;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      a2_r    <= a1_r;
      mb2_r   <= mb2_nxt;
      temp2_r <= temp1_r;
    end
  end

  always_comb begin
    bfac  = (mb2_r + HUM_B_ROUND) >>> 14;
    x_nxt = a2_r * bfac;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      x3_r    <= x_nxt;
      temp3_r <= temp2_r;
    end
  end

  always_comb begin
    s15    = x3_r >>> 15;
    sq_nxt = s15 * s15;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      x4_r    <= x3_r;
      sq_r    <= sq_nxt;
      temp4_r <= temp3_r;
    end
  end

  assign mh_nxt = (sq_r >>> 7) * h1;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      x5_r    <= x4_r;
      mh_r    <= mh_nxt;
      temp5_r <= temp4_r;
    end
  end

  always_comb begin
    r_full = x5_r - (mh_r >>> 4);
    if (r_full < 32'sd0) begin
      hum_nxt = '0;
    end else if (r_full > HUM_MAX) begin
      hum_nxt = HUM_MAX[28:12];
    end else begin
      hum_nxt = r_full[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      hum_r   <= hum_nxt;
      temp6_r <= temp5_r;
    end
  end

  assign out_data.temp_centi = temp6_r;
  assign out_data.hum_q10    = hum_r;

endmodule

FILE: src/humidity_temperature_compensation_core.sv
`timescale 1ns / 1ps
// Temperature and humidity compensation core.
// Input channel (in_valid/in_ready/in_data): one request carries a raw
// 20-bit temperature and a raw 16-bit humidity reading.
// Output channel (out_valid/out_ready/out_data): one result per request,
// temperature in 0.01 degC (saturated -4000..8500) and humidity in
// 1/1024 %RH (clamped 0..102400), in request order.
// Calibration words are written over the APB port (psel/penable/pwrite,
// byte address 4*index); reads return them. The user must write them only
// while no request is in flight; the block does not enforce this. The pipeline
// has 4 temperature and 7 humidity stages, at most one 32-bit multiply on any
// path through a stage. Throughput is one request per cycle while out_ready
// is high. Each stage holds its own valid bit and loads whenever it is empty
// or the stage after it moves, so bubbles close up and in_ready stays high
// while a result waits, until all stages are full. A stalled out_ready holds
// out_data and loses nothing. Synchronous active-low reset empties the
// pipeline and clears all calibration registers to zero.
module humidity_temperature_compensation_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  htc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output htc_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import htc_pkg::*;

  cal_t      cal_r;
  reg_idx_t  reg_idx;
  logic      wr_en;
  logic      mid_valid, mid_ready;
  temp_res_t mid_data;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TEMP_CAL_ONE:   cal_r.temp_cal_one            <= pwdata[15:0];
        REG_TEMP_CAL_TWO:   cal_r.temp_cal_two            <= pwdata[15:0];
        REG_TEMP_CAL_THREE: cal_r.temp_cal_three          <= pwdata[15:0];
        REG_HUM_CAL_ONE:    cal_r.hum_cal_one             <= pwdata[7:0];
        REG_HUM_CAL_TWO:    cal_r.hum_cal_two             <= pwdata[15:0];
        REG_HUM_CAL_THREE:  cal_r.hum_cal_three           <= pwdata[7:0];
        REG_HUM_CAL_FOUR5:  cal_r.hum_cal_four_five_bytes <= pwdata[23:0];
        REG_HUM_CAL_SIX:    cal_r.hum_cal_six             <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEMP_CAL_ONE:   prdata = {16'd0, cal_r.temp_cal_one};
      REG_TEMP_CAL_TWO:   prdata = {16'd0, cal_r.temp_cal_two};
      REG_TEMP_CAL_THREE: prdata = {16'd0, cal_r.temp_cal_three};
      REG_HUM_CAL_ONE:    prdata = {24'd0, cal_r.hum_cal_one};
      REG_HUM_CAL_TWO:    prdata = {16'd0, cal_r.hum_cal_two};
      REG_HUM_CAL_THREE:  prdata = {24'd0, cal_r.hum_cal_three};
      REG_HUM_CAL_FOUR5:  prdata = {8'd0, cal_r.hum_cal_four_five_bytes};
      REG_HUM_CAL_SIX:    prdata = {24'd0, cal_r.hum_cal_six};
      default:            prdata = '0;
    endcase
  end

  htc_temp_pipe u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  htc_hum_pipe u_hum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/htc_checker.sv
`timescale 1ns / 1ps
module htc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input htc_pkg::in_item_t             in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input htc_pkg::out_item_t            out_data,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [htc_pkg::PADDR_W-1:0]   paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready
);
  import htc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.temp_centi >= -15'sd4000) && (out_data.temp_centi <= 15'sd8500))
    else $error("temperature out of range");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hum_q10 <= 17'd102400)
    else $error("humidity out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind humidity_temperature_compensation_core htc_checker u_htc_checker (.*);
